>>> design/scrs_pkg.sv
package scrs_pkg;

  localparam int POS_BITS   = 18;
  localparam int TYPE_BITS  = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 48;
  localparam int RSQ_W      = 40;
  localparam int AXIS_W     = 48;
  localparam int COS_W      = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X        = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y        = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Z        = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_RADIUS_SQ = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_RADIUS_SQ = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CAP_AXIS        = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COS_HALF_ANGLE  = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WANTED_TYPE     = 8'd7;

  localparam logic [COS_W-1:0] COS_RESET = 16'd16384;

  typedef struct packed {
    logic [POS_BITS-1:0]  head_x;
    logic [POS_BITS-1:0]  head_y;
    logic [POS_BITS-1:0]  head_z;
    logic [TYPE_BITS-1:0] kind;
    logic                 has_head;
  } in_t;

  typedef struct packed {
    logic selected;
    logic type_match;
    logic in_shell;
  } out_t;

endpackage

>>> design/spherical_cap_region_select_core.sv
// Spherical cap region selector.
// Input channel (in_valid / in_stall / in_data): one polymer per item, head
// bead position, type number and head flag. Output channel (out_valid /
// out_stall / out_data): one result per item, in order: selected, type_match,
// in_shell. An item moves when valid is high and stall is low.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data): one
// register write per handshake; cfg_ready is always high; indexes beyond
// the register list are dropped. Write only while no item is in flight.
// Throughput: one item per cycle while out_stall is low; the pipeline has
// seven stages (offsets, squares and axis products, sums, shell test, split
// partial products of the two sides of the cosine test, their sums, final
// compare).
// Each stage advances when it is empty or the next stage moves, so bubbles
// close up; while out_stall is high the held result stays unchanged and
// in_stall rises once every stage is full.
// Reset clears all stage valids and restores the register reset values
// (all zero, cosine of the half angle 1.0).
module spherical_cap_region_select_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  scrs_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output scrs_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [scrs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [scrs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import scrs_pkg::*;

  localparam int P      = POS_BITS;
  localparam int MW     = (P < 21) ? P : 21;
  localparam int WW     = (P > 22) ? P : 22;
  localparam int D      = MW + 1;
  localparam int SQ_W   = 2 * MW;
  localparam int SUM_W  = 45;
  localparam int PW     = COS_W + D;
  localparam int DOT_W  = PW + 2;
  localparam int DM_W   = DOT_W - 1;
  localparam int LO_W   = (DM_W + 1) / 2;
  localparam int HI_W   = DM_W - LO_W;
  localparam int LHS_W  = 2 * DM_W;
  localparam int CSQ_W  = 2 * COS_W;
  localparam int RH_W   = RSQ_W / 2;
  localparam int RHS_W  = CSQ_W + RSQ_W;
  localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;
  localparam logic [WW-1:0]    MagLimit = WW'(1) << 21;
  localparam logic [SUM_W-1:0] RsqCap   = SUM_W'(1) << 44;

  // configuration registers
  logic [P-1:0]         centre [3];
  logic [RSQ_W-1:0]     inner_radius_sq;
  logic [RSQ_W-1:0]     outer_radius_sq;
  logic [AXIS_W-1:0]    cap_axis;
  logic [COS_W-1:0]     cos_half_angle;
  logic [TYPE_BITS-1:0] wanted_type;
  logic [COS_W-1:0]     cos_mag;
  logic [CSQ_W-1:0]     cos_sq;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre[0]       <= '0;
      centre[1]       <= '0;
      centre[2]       <= '0;
      inner_radius_sq <= '0;
      outer_radius_sq <= '0;
      cap_axis        <= '0;
      cos_half_angle  <= COS_RESET;
      wanted_type     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CENTRE_X:        centre[0]       <= cfg_data[P-1:0];
        REG_CENTRE_Y:        centre[1]       <= cfg_data[P-1:0];
        REG_CENTRE_Z:        centre[2]       <= cfg_data[P-1:0];
        REG_INNER_RADIUS_SQ: inner_radius_sq <= cfg_data[RSQ_W-1:0];
        REG_OUTER_RADIUS_SQ: outer_radius_sq <= cfg_data[RSQ_W-1:0];
        REG_CAP_AXIS:        cap_axis        <= cfg_data[AXIS_W-1:0];
        REG_COS_HALF_ANGLE:  cos_half_angle  <= cfg_data[COS_W-1:0];
        REG_WANTED_TYPE:     wanted_type     <= cfg_data[TYPE_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cos_mag = cos_half_angle[COS_W-1] ? (~cos_half_angle + 1'b1) : cos_half_angle;

  // follows the register every cycle; used from stage 5 on
  always_ff @(posedge clk) begin
    cos_sq <= CSQ_W'(cos_mag) * CSQ_W'(cos_mag);
  end

  // stage flow control
  logic [7:1] v;
  logic [7:1] en;

  always_comb begin
    en[7] = !v[7] || !out_stall;
    for (int k = 6; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_stall  = !en[1];
  assign out_valid = v[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= in_valid;
      for (int k = 2; k <= 7; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 1: offsets from the centre, type match
  logic [P-1:0]        pos [3];
  logic signed [P:0]   s1_d [3];
  logic                s1_tm;
  logic                s1_hd;

  assign pos[0] = in_data.head_x;
  assign pos[1] = in_data.head_y;
  assign pos[2] = in_data.head_z;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        s1_d[i] <= $signed({1'b0, pos[i]}) - $signed({1'b0, centre[i]});
      end
      s1_tm <= in_data.kind == wanted_type;
      s1_hd <= in_data.has_head;
    end
  end

  // stage 2: magnitudes, squares, axis products
  logic [P:0]             mag_full [3];
  logic [3:0]             sat_c;
  logic [MW-1:0]          m_c [3];
  logic signed [D-1:0]    dn_c [3];
  logic signed [COS_W-1:0] ax_c [3];
  logic [SQ_W-1:0]        s2_sq [3];
  logic signed [PW-1:0]   s2_pr [3];
  logic                   s2_sat;
  logic                   s2_tm;
  logic                   s2_hd;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_full[i] = s1_d[i][P] ? (~s1_d[i] + 1'b1) : s1_d[i];
      sat_c[i]    = WW'(mag_full[i][P-1:0]) >= MagLimit;
      m_c[i]      = sat_c[i] ? '0 : MW'(mag_full[i][P-1:0]);
      dn_c[i]     = sat_c[i] ? '0 : $signed(s1_d[i][D-1:0]);
      ax_c[i]     = $signed(cap_axis[COS_W*i +: COS_W]);
    end
    sat_c[3] = sat_c[0] || sat_c[1] || sat_c[2];
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        s2_sq[i] <= SQ_W'(m_c[i]) * SQ_W'(m_c[i]);
        s2_pr[i] <= ax_c[i] * dn_c[i];
      end
      s2_sat <= sat_c[3];
      s2_tm  <= s1_tm;
      s2_hd  <= s1_hd;
    end
  end

  // stage 3: squared distance and dot product
  logic [SUM_W-1:0]        s3_rsq;
  logic signed [DOT_W-1:0] s3_dot;
  logic                    s3_tm;
  logic                    s3_hd;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_rsq <= s2_sat ? RsqCap
                       : SUM_W'(s2_sq[0]) + SUM_W'(s2_sq[1]) + SUM_W'(s2_sq[2]);
      s3_dot <= DOT_W'(s2_pr[0]) + DOT_W'(s2_pr[1]) + DOT_W'(s2_pr[2]);
      s3_tm  <= s2_tm;
      s3_hd  <= s2_hd;
    end
  end

  // stage 4: shell test, dot magnitude
  logic [DOT_W-1:0]  dot_abs;
  logic [DM_W-1:0]   s4_dm;
  logic              s4_dneg;
  logic [RSQ_W-1:0]  s4_rsq;
  logic              s4_shell;
  logic              s4_tm;

  assign dot_abs = s3_dot[DOT_W-1] ? (~s3_dot + 1'b1) : s3_dot;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_shell <= s3_hd && (s3_rsq > SUM_W'(inner_radius_sq))
                        && (s3_rsq < SUM_W'(outer_radius_sq));
      s4_dm    <= dot_abs[DM_W-1:0];
      s4_dneg  <= s3_dot[DOT_W-1];
      s4_rsq   <= s3_rsq[RSQ_W-1:0];
      s4_tm    <= s3_tm;
    end
  end

  // stage 5: partial products of dot^2 and c^2 * dist^2
  logic [LO_W-1:0]          dm_lo;
  logic [HI_W-1:0]          dm_hi;
  logic [2*LO_W-1:0]        s5_pll;
  logic [HI_W+LO_W-1:0]     s5_phl;
  logic [2*HI_W-1:0]        s5_phh;
  logic [CSQ_W+RH_W-1:0]    s5_rl;
  logic [CSQ_W+RH_W-1:0]    s5_rh;
  logic                     s5_dneg;
  logic                     s5_shell;
  logic                     s5_tm;

  assign dm_lo = s4_dm[LO_W-1:0];
  assign dm_hi = s4_dm[DM_W-1:LO_W];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_pll   <= (2*LO_W)'(dm_lo) * (2*LO_W)'(dm_lo);
      s5_phl   <= (HI_W+LO_W)'(dm_hi) * (HI_W+LO_W)'(dm_lo);
      s5_phh   <= (2*HI_W)'(dm_hi) * (2*HI_W)'(dm_hi);
      s5_rl    <= (CSQ_W+RH_W)'(cos_sq) * (CSQ_W+RH_W)'(s4_rsq[RH_W-1:0]);
      s5_rh    <= (CSQ_W+RH_W)'(cos_sq) * (CSQ_W+RH_W)'(s4_rsq[RSQ_W-1:RH_W]);
      s5_dneg  <= s4_dneg;
      s5_shell <= s4_shell;
      s5_tm    <= s4_tm;
    end
  end

  // stage 6: assemble both sides
  logic [LHS_W-1:0] s6_lhs;
  logic [RHS_W-1:0] s6_rhs;
  logic             s6_dneg;
  logic             s6_shell;
  logic             s6_tm;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_lhs   <= (LHS_W'(s5_phh) << (2*LO_W)) + (LHS_W'(s5_phl) << (LO_W+1))
                + LHS_W'(s5_pll);
      s6_rhs   <= (RHS_W'(s5_rh) << RH_W) + RHS_W'(s5_rl);
      s6_dneg  <= s5_dneg;
      s6_shell <= s5_shell;
      s6_tm    <= s5_tm;
    end
  end

  // stage 7: sign-aware cone test, result register
  logic c_neg;
  logic lhs_gt;
  logic lhs_lt;
  logic cone;

  assign c_neg  = cos_half_angle[COS_W-1];
  assign lhs_gt = CMP_W'(s6_lhs) > CMP_W'(s6_rhs);
  assign lhs_lt = CMP_W'(s6_lhs) < CMP_W'(s6_rhs);

  always_comb begin
    priority if (!s6_dneg && c_neg) begin
      cone = 1'b1;
    end else if (s6_dneg && !c_neg) begin
      cone = 1'b0;
    end else if (!s6_dneg) begin
      cone = lhs_gt;
    end else begin
      cone = lhs_lt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      out_data.selected   <= s6_tm && s6_shell && cone;
      out_data.type_match <= s6_tm;
      out_data.in_shell   <= s6_shell;
    end
  end

endmodule
